>>> design/mdio_clause45_master_regs_assert.svh
// assertion macros shared by the mdio clause 45 master rtl
// needs nothing but a clock and an active-low reset at the point of use
`ifndef MDIO_CLAUSE45_MASTER_REGS_ASSERT_SVH
`define MDIO_CLAUSE45_MASTER_REGS_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define MDIOC45_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mdioc45 check failed");

// next-cycle implication, off while reset is asserted
`define MDIOC45_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mdioc45 check failed");

`endif

>>> design/mdioc45_pkg.sv
// shared types and constants for the mdio clause 45 master
// no dependencies
package mdioc45_pkg;

	// frame layout
	localparam int PREAMBLE_BITS = 32;
	localparam int FRAME_BITS    = PREAMBLE_BITS + 32;
	localparam int BC_W          = 7;

	// frame header codes
	localparam logic [1:0] FRAME_ST       = 2'b00;
	localparam logic [1:0] FRAME_TA       = 2'b10;
	localparam logic [1:0] FRAME_OP_ADDR  = 2'b00;
	localparam logic [1:0] FRAME_OP_WRITE = 2'b01;
	localparam logic [1:0] FRAME_OP_READ  = 2'b11;

	// register access codes
	localparam logic [1:0] OP_IDLE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// register word offsets
	localparam logic [2:0] REG_CFG    = 3'd0;
	localparam logic [2:0] REG_CMD    = 3'd1;
	localparam logic [2:0] REG_WRDAT  = 3'd2;
	localparam logic [2:0] REG_RDDAT  = 3'd3;
	localparam logic [2:0] REG_STATUS = 3'd4;
	localparam logic [2:0] REG_MASK   = 3'd5;
	localparam logic [2:0] REG_SRC    = 3'd6;
	localparam logic [2:0] REG_RESET  = 3'd7;

	localparam logic [7:0]  MDC_DIV_RESET = 8'd49;
	localparam logic [31:0] CMD_KEEP_MASK = 32'hFFFF_1F9F;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  reg_offset;
		logic [31:0] write_data;
		logic        mdio_in;
	} mdioc45_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        mdc_level;
		logic        mdio_out;
		logic        mdio_drive;
		logic        irq;
	} mdioc45_rsp_t;

	// control into the register/engine core
	typedef struct packed {
		logic       step;
		logic       cfg_we;
		logic [7:0] cfg_wdata;
	} mdioc45_ctl_t;

endpackage

>>> design/mdioc45_core.sv
// register file and mdio frame engine, one tick per step
// depends on mdioc45_pkg and the assertion macro header
`include "mdio_clause45_master_regs_assert.svh"

module mdioc45_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mdioc45_pkg::mdioc45_ctl_t ctl,
	input  mdioc45_pkg::mdioc45_req_t req,
	output mdioc45_pkg::mdioc45_rsp_t rsp
);
	import mdioc45_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ADDR = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	localparam logic [BC_W-1:0] BC_DRV_OFF = BC_W'(PREAMBLE_BITS + 14);
	localparam logic [BC_W-1:0] BC_TA2     = BC_W'(PREAMBLE_BITS + 15);
	localparam logic [BC_W-1:0] BC_DATA    = BC_W'(PREAMBLE_BITS + 16);
	localparam logic [BC_W-1:0] BC_END     = BC_W'(FRAME_BITS);
	localparam int PRE_SHIFT  = 64 - PREAMBLE_BITS;
	localparam int BODY_SHIFT = 32 - PREAMBLE_BITS;

	function automatic logic [63:0] make_frame(input logic [1:0] op, input logic [31:0] cmd,
		input logic [15:0] data);
		logic [63:0] body;
		logic [63:0] pre;
		body = {32'd0, FRAME_ST, op, cmd[12:8], cmd[4:0], FRAME_TA, data};
		pre  = (PREAMBLE_BITS == 0) ? 64'd0 : (~64'd0 << PRE_SHIFT);
		return pre | (body << BODY_SHIFT);
	endfunction

	logic [7:0]      div_q, n_div;
	logic [31:0]     cmd_q, n_cmd;
	logic [15:0]     wr_q, n_wr;
	logic [15:0]     rd_q, n_rd;
	logic            done_q, n_done;
	logic            err_q, n_err;
	logic [1:0]      mask_q, n_mask;
	logic [1:0]      ph_q, n_ph;
	logic [BC_W-1:0] bc_q, n_bc;
	logic [63:0]     sf_q, n_sf;
	logic [7:0]      cdc_q, n_cdc;
	logic            cl_q, n_cl;
	logic            is_rd;
	logic            drive;
	logic [1:0]      status;

	always_comb begin
		n_div  = div_q;
		n_cmd  = cmd_q;
		n_wr   = wr_q;
		n_rd   = rd_q;
		n_done = done_q;
		n_err  = err_q;
		n_mask = mask_q;
		n_ph   = ph_q;
		n_bc   = bc_q;
		n_sf   = sf_q;
		n_cdc  = cdc_q;
		n_cl   = cl_q;
		is_rd  = cmd_q[7];
		rsp    = '0;

		// engine tick
		if (ph_q != PH_IDLE) begin
			if (cdc_q < div_q) begin
				n_cdc = cdc_q + 8'd1;
			end else begin
				n_cdc = 8'd0;
				if (!cl_q) begin
					n_cl = 1'b1;
					if (ph_q == PH_DATA && is_rd) begin
						if (bc_q == BC_TA2 && req.mdio_in)
							n_err = 1'b1;
						if (bc_q >= BC_DATA)
							n_rd = {rd_q[14:0], req.mdio_in};
					end
				end else begin
					n_cl = 1'b0;
					n_bc = bc_q + BC_W'(1);
					n_sf = sf_q << 1;
					if (n_bc >= BC_END) begin
						if (ph_q == PH_ADDR) begin
							n_ph = PH_DATA;
							n_bc = '0;
							n_sf = is_rd ? make_frame(FRAME_OP_READ, cmd_q, 16'd0)
							             : make_frame(FRAME_OP_WRITE, cmd_q, wr_q);
						end else begin
							n_ph   = PH_IDLE;
							n_bc   = '0;
							n_sf   = '0;
							n_cdc  = 8'd0;
							n_cl   = 1'b0;
							n_done = 1'b1;
						end
					end
				end
			end
		end

		status = {n_err, n_done};

		// register access after the engine
		if (req.operation == OP_READ) begin
			unique case (req.reg_offset)
				REG_CFG:    rsp.read_data = {24'd0, div_q};
				REG_CMD:    rsp.read_data = cmd_q;
				REG_WRDAT:  rsp.read_data = {16'd0, wr_q};
				REG_RDDAT:  rsp.read_data = {16'd0, n_rd};
				REG_STATUS: rsp.read_data = {30'd0, status};
				REG_MASK:   rsp.read_data = {30'd0, mask_q};
				REG_SRC:    rsp.read_data = {30'd0, status & ~mask_q};
				REG_RESET:  rsp.read_data = 32'd0;
			endcase
		end else if (req.operation == OP_WRITE) begin
			unique case (req.reg_offset)
				REG_CFG:   n_div = req.write_data[7:0];
				REG_CMD: begin
					if (n_ph == PH_IDLE) begin
						n_cmd = req.write_data & CMD_KEEP_MASK;
						n_ph  = PH_ADDR;
						n_bc  = '0;
						n_cdc = 8'd0;
						n_cl  = 1'b0;
						n_sf  = make_frame(FRAME_OP_ADDR, n_cmd, n_cmd[31:16]);
					end
				end
				REG_WRDAT: n_wr = req.write_data[15:0];
				REG_STATUS: begin
					if (req.write_data[0])
						n_done = 1'b0;
					if (req.write_data[1])
						n_err = 1'b0;
				end
				REG_MASK:  n_mask = req.write_data[1:0];
				REG_RESET: begin
					if (req.write_data[0]) begin
						n_ph   = PH_IDLE;
						n_bc   = '0;
						n_sf   = '0;
						n_cdc  = 8'd0;
						n_cl   = 1'b0;
						n_done = 1'b0;
						n_err  = 1'b0;
					end
				end
				REG_RDDAT, REG_SRC: ;
			endcase
		end

		if (ctl.cfg_we)
			n_div = ctl.cfg_wdata;

		drive = (n_ph != PH_IDLE)
			&& !(n_ph == PH_DATA && n_cmd[7] && n_bc >= BC_DRV_OFF);
		rsp.mdc_level  = n_cl;
		rsp.mdio_drive = drive;
		rsp.mdio_out   = drive & n_sf[63];
		rsp.irq        = (n_done & ~n_mask[0]) | (n_err & ~n_mask[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= MDC_DIV_RESET;
			cmd_q  <= '0;
			wr_q   <= '0;
			rd_q   <= '0;
			done_q <= 1'b0;
			err_q  <= 1'b0;
			mask_q <= 2'b11;
			ph_q   <= PH_IDLE;
			bc_q   <= '0;
			sf_q   <= '0;
			cdc_q  <= '0;
			cl_q   <= 1'b0;
		end else if (ctl.step) begin
			div_q  <= n_div;
			cmd_q  <= n_cmd;
			wr_q   <= n_wr;
			rd_q   <= n_rd;
			done_q <= n_done;
			err_q  <= n_err;
			mask_q <= n_mask;
			ph_q   <= n_ph;
			bc_q   <= n_bc;
			sf_q   <= n_sf;
			cdc_q  <= n_cdc;
			cl_q   <= n_cl;
		end else if (ctl.cfg_we) begin
			div_q <= ctl.cfg_wdata;
		end
	end

	`MDIOC45_ASSERT_IMPL(a_idle_mdc_low, clk, arst_n, ph_q == PH_IDLE, !cl_q && bc_q == '0)
	`MDIOC45_ASSERT_IMPL(a_bc_in_frame, clk, arst_n, 1'b1, bc_q < BC_END)
	`MDIOC45_ASSERT_IMPL(a_done_from_data, clk, arst_n, $rose(done_q), $past(ph_q) == PH_DATA)

endmodule

>>> design/mdio_clause45_master_regs.sv
// top level of the mdio clause 45 master: input stage, core, result stage
// depends on mdioc45_pkg, mdioc45_core and the assertion macro header
//
//  channel  direction  handshake             beat
//  req      in         req_valid/req_ready   one tick, optional register access
//  rsp      out        rsp_valid/rsp_ready   register read data and pin levels
//  cfg      in         cfg_we                mdc divider, no back-pressure
//
// one beat per cycle sustained while rsp is not stalled; each beat passes through the input stage
// (where the core applies its tick) and then sits in the result register
// a stalled result holds the result register; the input stage still takes a
// beat, and req_ready drops only when both stages are full and rsp is stalled
// reset clears both stage valids and the core: idle engine, divider 49,
// interrupt masks set
`include "mdio_clause45_master_regs_assert.svh"

module mdio_clause45_master_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  mdioc45_pkg::mdioc45_req_t req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output mdioc45_pkg::mdioc45_rsp_t rsp,
	input  logic                      cfg_we,
	input  logic [7:0]                cfg_wdata
);
	import mdioc45_pkg::*;

	logic         valid_s1;
	mdioc45_req_t req_s1;
	logic         valid_s2;
	mdioc45_rsp_t rsp_s2;
	logic         out_free;
	logic         step;
	mdioc45_ctl_t ctl;
	mdioc45_rsp_t core_rsp;

	// result register can load when empty or being drained this cycle
	assign out_free  = !valid_s2 || rsp_ready;
	// the core ticks exactly once per beat, as it leaves the input stage
	assign step      = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;

	assign ctl.step      = step;
	assign ctl.cfg_we    = cfg_we;
	assign ctl.cfg_wdata = cfg_wdata;

	mdioc45_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req_s1),
		.rsp    (core_rsp)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			rsp_s2 <= core_rsp;
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	`MDIOC45_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, !req_ready,
		valid_s1 && valid_s2 && !rsp_ready)
	`MDIOC45_ASSERT_IMPL(a_out_needs_drive, clk, arst_n, rsp_valid && rsp.mdio_out,
		rsp.mdio_drive)
	`MDIOC45_ASSERT_NEXT(a_step_fills_out, clk, arst_n, step, valid_s2)

endmodule

>>> sim/tb_mdio_clause45_master_regs.sv
// self-checking testbench for the mdio clause 45 master: one tick per request beat, one
// response beat per tick compared against a cycle-exact model of the frame engine
// depends on mdioc45_pkg and mdio_clause45_master_regs
`timescale 1ns / 100ps

module tb_mdio_clause45_master_regs;
	import mdioc45_pkg::*;

	// access code the block treats as an idle tick
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// command word: read/write select bit
	localparam int CMD_READ_BIT = 7;

	// run control
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_AT      = 400;   // response count that triggers the long stall
	localparam int HOLD_CYCLES  = 80;
	localparam int CALM_LO      = 600;   // window with no idling on either side
	localparam int CALM_HI      = 800;
	localparam int RANDOM_PHASE = 80;    // ticks per random phase

	typedef enum logic [1:0] {FR_IDLE, FR_ADDR, FR_DATA} frame_phase_e;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         req_valid;
	logic         req_ready;
	mdioc45_req_t req;
	logic         rsp_valid;
	logic         rsp_ready;
	mdioc45_rsp_t rsp;
	logic         cfg_we;
	logic [7:0]   cfg_wdata;

	mdio_clause45_master_regs dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// ---------------------------------------------------------------------
	// model of the master: register file plus frame engine
	// ---------------------------------------------------------------------
	logic [7:0]      m_div;
	logic [31:0]     m_cmd;
	logic [15:0]     m_wrword;
	logic [15:0]     m_rdword;
	logic            m_done;
	logic            m_err;
	logic [1:0]      m_mask;
	frame_phase_e    m_phase;
	logic [BC_W-1:0] m_bits;
	logic [63:0]     m_shift;
	logic [7:0]      m_divcnt;
	logic            m_mdc;

	// tick results in beat order, oldest first
	mdioc45_rsp_t tick_results_q[$];

	int errors       = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int cycle_count  = 0;

	// left-aligned frame: preamble ones, then st, op, phyad, devad, ta, data
	function automatic logic [63:0] frame_bits(input logic [1:0] op, input logic [15:0] data);
		logic [31:0] body;
		logic [63:0] pre;
		body = {FRAME_ST, op, m_cmd[12:8], m_cmd[4:0], FRAME_TA, data};
		pre = (PREAMBLE_BITS == 0) ? 64'd0 : (~64'd0 << (64 - PREAMBLE_BITS));
		return pre | ({32'd0, body} << (32 - PREAMBLE_BITS));
	endfunction

	function automatic void park_engine();
		m_phase  = FR_IDLE;
		m_bits   = '0;
		m_shift  = '0;
		m_divcnt = '0;
		m_mdc    = 1'b0;
	endfunction

	// one controller tick: engine advances first, then the register access
	function automatic mdioc45_rsp_t mdio_master_tick(input mdioc45_req_t t);
		mdioc45_rsp_t o;
		logic [1:0]   st;
		o = '0;

		// engine step
		if (m_phase != FR_IDLE) begin
			if (m_divcnt < m_div) begin
				m_divcnt++;
			end else begin
				m_divcnt = '0;
				if (!m_mdc) begin
					// rising mdc: read frames sample the pin here
					m_mdc = 1'b1;
					if (m_phase == FR_DATA && m_cmd[CMD_READ_BIT]) begin
						if (m_bits == PREAMBLE_BITS + 15 && t.mdio_in)
							m_err = 1'b1;
						if (m_bits >= PREAMBLE_BITS + 16)
							m_rdword = {m_rdword[14:0], t.mdio_in};
					end
				end else begin
					// falling mdc: next bit goes out
					m_mdc = 1'b0;
					m_bits++;
					m_shift = m_shift << 1;
					if (m_bits >= PREAMBLE_BITS + 32) begin
						if (m_phase == FR_ADDR) begin
							// data frame built from cmd and wrdat as they are now
							m_phase = FR_DATA;
							m_bits  = '0;
							m_shift = m_cmd[CMD_READ_BIT] ? frame_bits(FRAME_OP_READ, 16'h0)
								: frame_bits(FRAME_OP_WRITE, m_wrword);
						end else begin
							park_engine();
							m_done = 1'b1;
						end
					end
				end
			end
		end

		// register access sees the state after the engine step
		st = {m_err, m_done};
		if (t.operation == OP_READ) begin
			case (t.reg_offset)
				REG_CFG:    o.read_data = {24'd0, m_div};
				REG_CMD:    o.read_data = m_cmd;
				REG_WRDAT:  o.read_data = {16'd0, m_wrword};
				REG_RDDAT:  o.read_data = {16'd0, m_rdword};
				REG_STATUS: o.read_data = {30'd0, st};
				REG_MASK:   o.read_data = {30'd0, m_mask};
				REG_SRC:    o.read_data = {30'd0, st & ~m_mask};
				default:    o.read_data = '0;
			endcase
		end else if (t.operation == OP_WRITE) begin
			case (t.reg_offset)
				REG_CFG: m_div = t.write_data[7:0];
				REG_CMD: begin
					// ignored while a frame is running
					if (m_phase == FR_IDLE) begin
						m_cmd = t.write_data & CMD_KEEP_MASK;
						park_engine();
						m_phase = FR_ADDR;
						m_shift = frame_bits(FRAME_OP_ADDR, m_cmd[31:16]);
					end
				end
				REG_WRDAT: m_wrword = t.write_data[15:0];
				REG_STATUS: begin
					// write one to clear, wins over a completion in the same tick
					if (t.write_data[0]) m_done = 1'b0;
					if (t.write_data[1]) m_err = 1'b0;
				end
				REG_MASK: m_mask = t.write_data[1:0];
				REG_RESET: begin
					if (t.write_data[0]) begin
						park_engine();
						m_done = 1'b0;
						m_err  = 1'b0;
					end
				end
				default: ;
			endcase
		end

		// pins after the whole tick; released from the first turnaround bit of a read
		o.mdc_level  = m_mdc;
		o.mdio_drive = (m_phase != FR_IDLE) && !(m_phase == FR_DATA && m_cmd[CMD_READ_BIT]
			&& m_bits >= PREAMBLE_BITS + 14);
		o.mdio_out   = o.mdio_drive & m_shift[63];
		o.irq        = (m_done & ~m_mask[0]) | (m_err & ~m_mask[1]);
		return o;
	endfunction

	// ---------------------------------------------------------------------
	// response side: ready pattern and checking
	// ---------------------------------------------------------------------

	// random stalls, one long hold-off, one stretch with ready held high
	initial begin : rsp_ready_ctl
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= ($urandom_range(99) >= 16);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			errors++;
		end
	endfunction

	// every response beat against the oldest tick result
	always @(posedge clk) begin : rsp_check
		mdioc45_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (tick_results_q.size() == 0) begin
				$error("response beat with no tick outstanding");
				errors++;
			end else begin
				want = tick_results_q.pop_front();
				check_field("read_data", want.read_data, rsp.read_data);
				check_field("mdc_level", 32'(want.mdc_level), 32'(rsp.mdc_level));
				check_field("mdio_out", 32'(want.mdio_out), 32'(rsp.mdio_out));
				check_field("mdio_drive", 32'(want.mdio_drive), 32'(rsp.mdio_drive));
				check_field("irq", 32'(want.irq), 32'(rsp.irq));
			end
			results_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------------

	function automatic mdioc45_req_t access(input logic [1:0] op, input logic [2:0] off,
		input logic [31:0] data, input logic mdio);
		mdioc45_req_t r;
		r.operation  = op;
		r.reg_offset = off;
		r.write_data = data;
		r.mdio_in    = mdio;
		return r;
	endfunction

	// one request beat, with random idle cycles in front outside the calm window
	task automatic send_tick(input mdioc45_req_t item);
		@(negedge clk);
		if ((items_sent < CALM_LO || items_sent >= CALM_HI) && $urandom_range(99) < 16) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 16);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		tick_results_q.push_back(mdio_master_tick(item));
		items_sent++;
	endtask

	// drop valid and wait until every response beat is back
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (tick_results_q.size() != 0) @(posedge clk);
	endtask

	// divider through the side port, only with the pipeline empty
	task automatic set_divider(input logic [7:0] v);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		m_div = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// idle ticks until the frame pair is over; the pin is forced high on the
	// second turnaround bit of a read frame when ta_high is set
	task automatic run_frames(input bit ta_high);
		logic pin;
		while (m_phase != FR_IDLE) begin
			pin = 1'($urandom_range(1));
			if (ta_high && m_phase == FR_DATA && m_bits == PREAMBLE_BITS + 15)
				pin = 1'b1;
			send_tick(access(OP_IDLE, 3'($urandom_range(7)), $urandom, pin));
		end
	endtask

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// reset values, field masking, ignored writes, busy command, reset bit
	task automatic test_register_file();
		for (int i = 0; i < 8; i++)
			send_tick(access(OP_READ, i[2:0], 32'h0, 1'b0));
		// unused access code must not start anything
		send_tick(access(OP_UNUSED, REG_CMD, 32'hFFFF_FFFF, 1'b1));
		send_tick(access(OP_WRITE, REG_WRDAT, 32'hFFFF_FFFF, 1'b0));
		send_tick(access(OP_READ, REG_WRDAT, 32'h0, 1'b1));
		send_tick(access(OP_WRITE, REG_RDDAT, 32'hFFFF_FFFF, 1'b0));
		send_tick(access(OP_WRITE, REG_SRC, 32'hFFFF_FFFF, 1'b0));
		send_tick(access(OP_READ, REG_RDDAT, 32'h0, 1'b0));
		send_tick(access(OP_WRITE, REG_MASK, 32'hFFFF_FFFC, 1'b1));
		send_tick(access(OP_READ, REG_MASK, 32'h0, 1'b0));
		send_tick(access(OP_WRITE, REG_CFG, 32'hFFFF_FF00, 1'b0));
		send_tick(access(OP_READ, REG_CFG, 32'h0, 1'b0));
		// reserved command bits dropped, then a command while busy
		send_tick(access(OP_WRITE, REG_CMD, 32'hFFFF_FFFF, 1'b1));
		send_tick(access(OP_READ, REG_CMD, 32'h0, 1'b1));
		send_tick(access(OP_WRITE, REG_CMD, 32'h0, 1'b0));
		send_tick(access(OP_READ, REG_CMD, 32'h0, 1'b0));
		// reset bit clear does nothing, set aborts the frame
		send_tick(access(OP_WRITE, REG_RESET, 32'hFFFF_FFFE, 1'b0));
		send_tick(access(OP_WRITE, REG_RESET, 32'h0000_0001, 1'b0));
		send_tick(access(OP_READ, REG_RESET, 32'h0, 1'b1));
		send_tick(access(OP_READ, REG_STATUS, 32'h0, 1'b0));
	endtask

	// complete write transaction at divider 0, then done and masking
	task automatic test_write_frame();
		send_tick(access(OP_WRITE, REG_WRDAT, $urandom, 1'b0));
		send_tick(access(OP_WRITE, REG_CMD, $urandom & ~(32'd1 << CMD_READ_BIT), 1'b0));
		run_frames(1'b0);
		send_tick(access(OP_READ, REG_STATUS, 32'h0, 1'b0));
		send_tick(access(OP_READ, REG_SRC, 32'h0, 1'b0));
		send_tick(access(OP_WRITE, REG_MASK, 32'h1, 1'b0));
		send_tick(access(OP_READ, REG_SRC, 32'h0, 1'b0));
		send_tick(access(OP_WRITE, REG_STATUS, 32'h1, 1'b0));
		send_tick(access(OP_WRITE, REG_MASK, 32'h0, 1'b0));
	endtask

	// read transaction where the phy leaves the second turnaround bit high
	task automatic test_read_frame_turnaround();
		set_divider(8'd0);
		send_tick(access(OP_WRITE, REG_CMD, $urandom | (32'd1 << CMD_READ_BIT), 1'b0));
		run_frames(1'b1);
		send_tick(access(OP_READ, REG_STATUS, 32'h0, 1'b0));
		send_tick(access(OP_READ, REG_SRC, 32'h0, 1'b0));
		send_tick(access(OP_READ, REG_RDDAT, 32'h0, 1'b0));
		send_tick(access(OP_WRITE, REG_STATUS, 32'h3, 1'b0));
		send_tick(access(OP_READ, REG_STATUS, 32'h0, 1'b0));
	endtask

	// largest divider: one slow mdc half period, then abort
	task automatic test_divider_extremes();
		set_divider(8'hFF);
		send_tick(access(OP_WRITE, REG_CMD, $urandom, 1'b0));
		repeat (270)
			send_tick(access(OP_IDLE, 3'($urandom_range(7)), $urandom,
				1'($urandom_range(1))));
		send_tick(access(OP_READ, REG_CFG, 32'h0, 1'b0));
		send_tick(access(OP_WRITE, REG_RESET, 32'h1, 1'b0));
		send_tick(access(OP_READ, REG_STATUS, 32'h0, 1'b0));
	endtask

	// mostly full transactions with random content, plus register noise
	task automatic test_random_traffic();
		logic [7:0]   div_set[4] = '{8'd0, 8'd1, 8'd0, 8'd0};
		mdioc45_req_t item;
		int           start;
		for (int ph = 0; ph < 4; ph++) begin
			set_divider(div_set[ph]);
			start = items_sent;
			while (items_sent - start < RANDOM_PHASE) begin
				if (m_phase == FR_IDLE && $urandom_range(99) < 60) begin
					// new transaction, sometimes with fresh write data first
					if ($urandom_range(1))
						send_tick(access(OP_WRITE, REG_WRDAT, $urandom,
							1'($urandom_range(1))));
					send_tick(access(OP_WRITE, REG_CMD, $urandom, 1'($urandom_range(1))));
				end else if (m_phase != FR_IDLE && $urandom_range(99) < 88) begin
					item = access(OP_IDLE, 3'($urandom_range(7)), $urandom,
						1'($urandom_range(1)));
					// status clear landing on the completing tick
					if (m_phase == FR_DATA && m_bits == PREAMBLE_BITS + 31 && m_mdc
						&& m_divcnt >= m_div && $urandom_range(1))
						item = access(OP_WRITE, REG_STATUS, $urandom, 1'($urandom_range(1)));
					send_tick(item);
				end else begin
					item = access(2'($urandom_range(3)), 3'($urandom_range(7)), $urandom,
						1'($urandom_range(1)));
					// keep mid-frame divider changes small so frames finish
					if (item.operation == OP_WRITE && item.reg_offset == REG_CFG)
						item.write_data[7:0] = 8'($urandom_range(3));
					// most reset writes leave the engine alone
					if (item.operation == OP_WRITE && item.reg_offset == REG_RESET
						&& $urandom_range(3) != 0)
						item.write_data[0] = 1'b0;
					send_tick(item);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;

		// model state after reset
		m_div    = MDC_DIV_RESET;
		m_cmd    = '0;
		m_wrword = '0;
		m_rdword = '0;
		m_done   = 1'b0;
		m_err    = 1'b0;
		m_mask   = 2'b11;
		park_engine();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_file();
		test_write_frame();
		test_read_frame_turnaround();
		test_divider_extremes();
		test_random_traffic();

		// drain, then keep watching for any stray beat
		settle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/mdioc45_pkg.sv
design/mdioc45_core.sv
design/mdio_clause45_master_regs.sv
sim/tb_mdio_clause45_master_regs.sv
